@@ src/vdia_pkg.sv @@
// Shared types and constants for the vertex dedup index assigner.
`default_nettype none

package vdia_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_INDEX_BITS   = 20;

    localparam int FIELD_W     = 20;
    localparam int VIDX_W      = 10;
    localparam int CNT_W       = 24;
    localparam int CELL_COUNT  = 8;
    localparam int CELL_BITS   = 3;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_UV      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMALS = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] position_index;
        logic [FIELD_W-1:0] texture_index;
        logic [FIELD_W-1:0] normal_index;
        logic               group_end;
    } in_item_t;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic              is_new;
        logic              table_full;
        logic [CNT_W-1:0]  group_first;
        logic [CNT_W-1:0]  group_count;
    } out_item_t;

    typedef struct packed {
        logic vld;
        logic hit;
    } cell_flag_t;

endpackage

`default_nettype wire

@@ src/vdia_cell.sv @@
// Search cell: one bank of stored keys, compares a passing probe and forwards it.
`default_nettype none

module vdia_cell #(
    parameter int MAX_VERTICES = vdia_pkg::DEF_MAX_VERTICES,
    parameter int INDEX_BITS   = vdia_pkg::DEF_INDEX_BITS,
    parameter int CELL_ID      = 0
) (
    input  wire                                              clk,
    input  wire                                              rst_n,
    input  wire vdia_pkg::cell_flag_t                        flag_in,
    input  wire [$clog2((MAX_VERTICES + vdia_pkg::CELL_COUNT - 1)
                        / vdia_pkg::CELL_COUNT)-1:0]         row_in,
    input  wire [3*INDEX_BITS-1:0]                           key_in,
    input  wire [$clog2(MAX_VERTICES)-1:0]                   vid_in,
    input  wire [$clog2(MAX_VERTICES+1)-1:0]                 fill,
    input  wire                                              wr_en,
    input  wire [$clog2((MAX_VERTICES + vdia_pkg::CELL_COUNT - 1)
                        / vdia_pkg::CELL_COUNT)-1:0]         wr_row,
    input  wire [3*INDEX_BITS-1:0]                           wr_key,
    output vdia_pkg::cell_flag_t                             flag_out,
    output logic [$clog2((MAX_VERTICES + vdia_pkg::CELL_COUNT - 1)
                         / vdia_pkg::CELL_COUNT)-1:0]        row_out,
    output logic [3*INDEX_BITS-1:0]                          key_out,
    output logic [$clog2(MAX_VERTICES)-1:0]                  vid_out
);
    import vdia_pkg::*;

    localparam int KEY_W      = 3 * INDEX_BITS;
    localparam int BANK_DEPTH = (MAX_VERTICES + CELL_COUNT - 1) / CELL_COUNT;
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam int FILL_W     = $clog2(MAX_VERTICES + 1);
    localparam int VID_W      = $clog2(MAX_VERTICES);
    localparam int GI_W       = ROW_W + CELL_BITS;
    localparam int CMP_W      = GI_W + FILL_W;
    localparam logic [CELL_BITS-1:0] MY_SLOT = CELL_BITS'(CELL_ID);

    logic [KEY_W-1:0] bank_mem [BANK_DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    cell_flag_t       s1_flag_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic [VID_W-1:0] s1_vid_reg;

    cell_flag_t       flag_out_reg;
    cell_flag_t       flag_out_next;
    logic [ROW_W-1:0] row_out_reg;
    logic [KEY_W-1:0] key_out_reg;
    logic [VID_W-1:0] vid_out_reg;
    logic [VID_W-1:0] vid_out_next;

    logic [GI_W-1:0]  gidx;
    logic             match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_mem[wr_row] <= wr_key;
        end
        rdata_reg <= bank_mem[row_in];
    end

    assign gidx  = {s1_row_reg, MY_SLOT};
    assign match = s1_flag_reg.vld && (CMP_W'(gidx) < CMP_W'(fill)) &&
                   (rdata_reg == s1_key_reg);

    always_comb
    begin
        flag_out_next.vld = s1_flag_reg.vld;
        flag_out_next.hit = s1_flag_reg.hit | match;
        vid_out_next      = s1_flag_reg.hit ? s1_vid_reg : VID_W'(gidx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_flag_reg  <= '0;
            flag_out_reg <= '0;
        end
        else
        begin
            s1_flag_reg  <= flag_in;
            flag_out_reg <= flag_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg  <= row_in;
        s1_key_reg  <= key_in;
        s1_vid_reg  <= vid_in;
        row_out_reg <= s1_row_reg;
        key_out_reg <= s1_key_reg;
        vid_out_reg <= vid_out_next;
    end

    assign flag_out = flag_out_reg;
    assign row_out  = row_out_reg;
    assign key_out  = key_out_reg;
    assign vid_out  = vid_out_reg;

endmodule

`default_nettype wire

@@ src/vertex_dedup_index_assigner_top.sv @@
// Top level of the vertex dedup index assigner: sequencer, counters and cell chain.
//
// Usage:
//   in_valid/in_ready/in_data carry one face corner per transfer; out_valid/
//   out_ready/out_data carry exactly one result per corner, in order.
//   cfg_write/cfg_index/cfg_data set uv_present (index 0) and normals_present
//   (index 1); write them only while the block is idle.
//   Stored keys sit in eight banks, one per cell. During the sweep a probe row
//   enters the chain every cycle and passes each cell through a bank read, then
//   a compare. With F vertices stored, a corner's search issues ceil(F/8) rows
//   (none while the table is empty); the sequencer waits until every row has
//   come back from the chain, then issues the result. One corner is in work at
//   a time; a new corner is taken only once the last result has been issued.
//   A finished result waits in the output register; the next corner is taken
//   meanwhile, and its result is held back until the register is free.
//   Reset empties the table at once (fill count) and zeroes all counters and
//   both configuration bits; no clearing pass is needed.
`default_nettype none

module vertex_dedup_index_assigner_top #(
    parameter int MAX_VERTICES = vdia_pkg::DEF_MAX_VERTICES,
    parameter int INDEX_BITS   = vdia_pkg::DEF_INDEX_BITS
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire vdia_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output vdia_pkg::out_item_t                    out_data,
    input  wire                                    cfg_write,
    input  wire [vdia_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire                                    cfg_data
);
    import vdia_pkg::*;

    localparam int KEY_W      = 3 * INDEX_BITS;
    localparam int BANK_DEPTH = (MAX_VERTICES + CELL_COUNT - 1) / CELL_COUNT;
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam int FILL_W     = $clog2(MAX_VERTICES + 1);
    localparam int VID_W      = $clog2(MAX_VERTICES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              uv_reg;
    logic              nrm_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  emitted_reg;
    logic [CNT_W-1:0]  gstart_reg;
    logic              group_end_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [ROW_W:0]    nrows_reg;
    logic [ROW_W:0]    issue_cnt_reg;
    logic [ROW_W:0]    ret_cnt_reg;
    logic              found_reg;
    logic [VID_W-1:0]  found_vid_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              in_fire;
    logic              done_fire;
    logic              issue;
    logic              table_full;
    logic              do_insert;
    logic [KEY_W-1:0]  key_next;
    logic [ROW_W:0]    nrows_next;
    logic [CNT_W-1:0]  emitted_next;
    out_item_t         result;

    logic [CELL_COUNT-1:0] cell_wr_en;
    logic [ROW_W-1:0]      cell_wr_row;

    cell_flag_t        chain_flag [CELL_COUNT+1];
    logic [ROW_W-1:0]  chain_row  [CELL_COUNT+1];
    logic [KEY_W-1:0]  chain_key  [CELL_COUNT+1];
    logic [VID_W-1:0]  chain_vid  [CELL_COUNT+1];
    cell_flag_t        tail_flag;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign issue     = (state_reg == ST_SWEEP) && (issue_cnt_reg != nrows_reg);
    assign tail_flag = chain_flag[CELL_COUNT];

    assign key_next = {INDEX_BITS'(in_data.position_index),
                       uv_reg  ? INDEX_BITS'(in_data.texture_index) : INDEX_BITS'(0),
                       nrm_reg ? INDEX_BITS'(in_data.normal_index)  : INDEX_BITS'(0)};
    assign nrows_next = (ROW_W+1)'(((FILL_W+1)'(fill_reg) + (FILL_W+1)'(CELL_COUNT - 1))
                                   >> CELL_BITS);

    assign table_full   = (fill_reg == FILL_W'(MAX_VERTICES));
    assign do_insert    = done_fire && !found_reg && !table_full;
    assign emitted_next = emitted_reg + CNT_W'(1);
    assign cell_wr_row  = ROW_W'(fill_reg >> CELL_BITS);

    always_comb
    begin
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            cell_wr_en[k] = do_insert && (fill_reg[CELL_BITS-1:0] == CELL_BITS'(k));
        end
    end

    always_comb
    begin
        result = '0;
        if (found_reg)
        begin
            result.vertex_index = VIDX_W'(found_vid_reg);
        end
        else if (table_full)
        begin
            result.table_full = 1'b1;
        end
        else
        begin
            result.vertex_index = VIDX_W'(fill_reg);
            result.is_new       = 1'b1;
        end
        if (group_end_reg)
        begin
            result.group_first = gstart_reg;
            result.group_count = emitted_next - gstart_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (issue_cnt_reg == nrows_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (ret_cnt_reg == nrows_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            uv_reg        <= 1'b0;
            nrm_reg       <= 1'b0;
            fill_reg      <= '0;
            emitted_reg   <= '0;
            gstart_reg    <= '0;
            issue_cnt_reg <= '0;
            ret_cnt_reg   <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_UV:      uv_reg  <= cfg_data;
                    CFG_NORMALS: nrm_reg <= cfg_data;
                    default:     ;
                endcase
            end

            if (in_fire)
            begin
                issue_cnt_reg <= '0;
                ret_cnt_reg   <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + (ROW_W+1)'(1);
                end
                if (tail_flag.vld)
                begin
                    ret_cnt_reg <= ret_cnt_reg + (ROW_W+1)'(1);
                    if (tail_flag.hit)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end

            if (done_fire)
            begin
                emitted_reg   <= emitted_next;
                out_valid_reg <= 1'b1;
                if (do_insert)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                if (group_end_reg)
                begin
                    gstart_reg <= emitted_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg       <= key_next;
            nrows_reg     <= nrows_next;
            group_end_reg <= in_data.group_end;
        end
        if (tail_flag.vld && tail_flag.hit)
        begin
            found_vid_reg <= chain_vid[CELL_COUNT];
        end
        if (done_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign chain_flag[0].vld = issue;
    assign chain_flag[0].hit = 1'b0;
    assign chain_row[0]      = issue_cnt_reg[ROW_W-1:0];
    assign chain_key[0]      = key_reg;
    assign chain_vid[0]      = '0;

    for (genvar g = 0; g < CELL_COUNT; g++)
    begin : g_cell
        vdia_cell #(
            .MAX_VERTICES (MAX_VERTICES),
            .INDEX_BITS   (INDEX_BITS),
            .CELL_ID      (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .flag_in  (chain_flag[g]),
            .row_in   (chain_row[g]),
            .key_in   (chain_key[g]),
            .vid_in   (chain_vid[g]),
            .fill     (fill_reg),
            .wr_en    (cell_wr_en[g]),
            .wr_row   (cell_wr_row),
            .wr_key   (key_reg),
            .flag_out (chain_flag[g+1]),
            .row_out  (chain_row[g+1]),
            .key_out  (chain_key[g+1]),
            .vid_out  (chain_vid[g+1])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_tail_key: assert property (@(posedge clk) disable iff (!rst_n)
        tail_flag.vld |-> chain_key[CELL_COUNT] == key_reg)
        else $error("probe key changed during search");

    a_tail_order: assert property (@(posedge clk) disable iff (!rst_n)
        tail_flag.vld |-> chain_row[CELL_COUNT] == ret_cnt_reg[ROW_W-1:0])
        else $error("probe rows returned out of order");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_VERTICES))
        else $error("fill count beyond table size");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        (|cell_wr_en) |-> ($onehot(cell_wr_en) && !tail_flag.vld && !issue))
        else $error("bank write overlaps a search");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for vertex_dedup_index_assigner_top: directed and random corners against a dedup predictor.
`timescale 1ns / 1ps

module tb_top;
    import vdia_pkg::*;

    localparam int TABLE_SIZE  = DEF_MAX_VERTICES;
    localparam int KEY_W       = 3 * FIELD_W;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 700;
    localparam int SETTLE      = 40;
    localparam logic [FIELD_W-1:0] F_MAX = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_UV;
    logic                   cfg_data  = 1'b0;

    // predictor state
    logic [KEY_W-1:0] stored_keys [TABLE_SIZE];
    int unsigned      stored_vertices = 0;
    logic [CNT_W-1:0] emitted_corners = '0;
    logic [CNT_W-1:0] group_base      = '0;
    logic             key_uv          = 1'b0;
    logic             key_normals     = 1'b0;
    out_item_t        pending_results [$];
    in_item_t         sent_corners [$];

    int     errors           = 0;
    int     refused          = 0;
    int     group_ends       = 0;
    int     accepted_corners = 0;
    int     checked_results  = 0;
    int     burst_left       = 0;
    int     holds_asked      = 0;
    int     holds_granted    = 0;
    int     hold_left        = 0;
    int     stall_pct        = 0;
    int     pattern_left     = 0;
    longint cycle_count      = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    vertex_dedup_index_assigner_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** vertex_dedup_index_assigner_top: FAILED **");
            $finish;
        end
    end

    // receiver: random stall pattern, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_granted != holds_asked)
        begin
            holds_granted++;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_left <= 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                pattern_left = $urandom_range(20, 250);
            end
            pattern_left--;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result transfer with no corner waiting for it");
            end
            else
            begin
                want = pending_results.pop_front();
                checked_results++;
                if (out_data.vertex_index !== want.vertex_index)
                begin
                    errors++;
                    $error("vertex_index: expected %0d, got %0d",
                           want.vertex_index, out_data.vertex_index);
                end
                if (out_data.is_new !== want.is_new)
                begin
                    errors++;
                    $error("is_new: expected %0d, got %0d", want.is_new, out_data.is_new);
                end
                if (out_data.table_full !== want.table_full)
                begin
                    errors++;
                    $error("table_full: expected %0d, got %0d",
                           want.table_full, out_data.table_full);
                end
                if (out_data.group_first !== want.group_first)
                begin
                    errors++;
                    $error("group_first: expected %0d, got %0d",
                           want.group_first, out_data.group_first);
                end
                if (out_data.group_count !== want.group_count)
                begin
                    errors++;
                    $error("group_count: expected %0d, got %0d",
                           want.group_count, out_data.group_count);
                end
            end
        end
    end

    function automatic void predict_corner(input in_item_t c);
        logic [KEY_W-1:0] key;
        out_item_t        r;
        bit               found;
        int               i;
        key   = {c.position_index,
                 c.texture_index & {FIELD_W{key_uv}},
                 c.normal_index & {FIELD_W{key_normals}}};
        r     = '0;
        found = 1'b0;
        for (i = 0; i < stored_vertices; i++)
        begin
            if (!found && stored_keys[i] == key)
            begin
                found = 1'b1;
                r.vertex_index = VIDX_W'(i);
            end
        end
        if (!found)
        begin
            if (stored_vertices < TABLE_SIZE)
            begin
                stored_keys[stored_vertices] = key;
                r.vertex_index = VIDX_W'(stored_vertices);
                r.is_new = 1'b1;
                stored_vertices++;
            end
            else
            begin
                r.table_full = 1'b1;
                refused++;
            end
        end
        emitted_corners = emitted_corners + 1'b1;
        if (c.group_end)
        begin
            r.group_first = group_base;
            r.group_count = emitted_corners - group_base;
            group_base    = emitted_corners;
            group_ends++;
        end
        pending_results.push_back(r);
    endfunction

    function automatic in_item_t corner(input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] t,
                                        input logic [FIELD_W-1:0] n, input logic g);
        in_item_t c;
        c.position_index = p;
        c.texture_index  = t;
        c.normal_index   = n;
        c.group_end      = g;
        return c;
    endfunction

    // fresh key, exact repeat of an earlier corner, or a repeat with one part changed
    function automatic in_item_t random_corner(input int fresh_pct);
        in_item_t c;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < fresh_pct || sent_corners.size() == 0)
        begin
            c.position_index = FIELD_W'($urandom);
            c.texture_index  = FIELD_W'($urandom);
            c.normal_index   = FIELD_W'($urandom);
        end
        else
        begin
            c = sent_corners[$urandom_range(0, sent_corners.size() - 1)];
            if (pick >= 80)
            begin
                if ($urandom_range(0, 1))
                    c.texture_index = FIELD_W'($urandom);
                else
                    c.normal_index = FIELD_W'($urandom);
            end
        end
        c.group_end = ($urandom_range(0, 5) == 0);
        return c;
    endfunction

    task automatic send_corner(input in_item_t c);
        int gap;
        @(negedge clk);
        if (burst_left <= 0)
        begin
            case ($urandom_range(0, 9)) inside
                [0:2]:   gap = 0;
                [3:7]:   gap = $urandom_range(1, 4);
                default: gap = $urandom_range(10, 60);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_corner(c);
        burst_left--;
        sent_corners.push_back(c);
        accepted_corners++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_key_parts(input logic uv, input logic nrm);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_UV;
        cfg_data  <= uv;
        @(negedge clk);
        cfg_index <= CFG_NORMALS;
        cfg_data  <= nrm;
        @(negedge clk);
        cfg_write <= 1'b0;
        key_uv      = uv;
        key_normals = nrm;
    endtask

    task automatic test_key_extremes();
        send_corner(corner('0, F_MAX, F_MAX, 1'b0));
        send_corner(corner(F_MAX, '0, '0, 1'b0));
        send_corner(corner('0, '0, '0, 1'b1));
        send_corner(corner(20'd1, 20'h12345, '0, 1'b0));
        send_corner(corner(F_MAX, F_MAX, F_MAX, 1'b1));
    endtask

    // masked parts, and keys stored under one setting probed under another
    task automatic test_key_parts();
        set_key_parts(1'b1, 1'b0);
        send_corner(corner('0, '0, '0, 1'b0));
        send_corner(corner('0, F_MAX, '0, 1'b0));
        send_corner(corner('0, F_MAX, 20'h55555, 1'b1));
        set_key_parts(1'b0, 1'b1);
        send_corner(corner('0, '0, F_MAX, 1'b0));
        send_corner(corner('0, 20'hAAAAA, F_MAX, 1'b0));
        set_key_parts(1'b1, 1'b1);
        send_corner(corner('0, F_MAX, F_MAX, 1'b0));
        send_corner(corner('0, F_MAX, F_MAX, 1'b0));
        send_corner(corner('0, '0, '0, 1'b0));
        send_corner(corner(F_MAX, F_MAX, F_MAX, 1'b1));
    endtask

    task automatic test_groups();
        send_corner(corner(20'd7, 20'd7, 20'd7, 1'b1));
        send_corner(corner(20'd7, 20'd7, 20'd7, 1'b1));
        send_corner(corner(20'd8, 20'd9, 20'd10, 1'b0));
        send_corner(corner(20'd8, 20'd9, 20'd10, 1'b0));
        send_corner(corner(20'd8, 20'd9, 20'd10, 1'b1));
    endtask

    task automatic test_random_mix(input logic uv, input logic nrm, input int count);
        int k;
        set_key_parts(uv, nrm);
        for (k = 0; k < count; k++)
            send_corner(random_corner(50));
    endtask

    // receiver holds off while corners keep coming, so the input stalls
    task automatic test_output_hold();
        int k;
        holds_asked++;
        burst_left = 24;
        for (k = 0; k < 24; k++)
            send_corner(random_corner(50));
        wait_idle();
    endtask

    task automatic test_fill_table();
        set_key_parts(1'b0, 1'b0);
        while (stored_vertices < TABLE_SIZE)
            send_corner(random_corner(78));
    endtask

    task automatic test_full_table();
        int k;
        set_key_parts(1'b1, 1'b1);
        for (k = 0; k < 60; k++)
            send_corner(random_corner(50));
        set_key_parts(1'b0, 1'b0);
        for (k = 0; k < 60; k++)
            send_corner(random_corner(50));
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_key_extremes();
        test_key_parts();
        test_groups();
        test_random_mix(1'b0, 1'b0, 180);
        test_random_mix(1'b1, 1'b1, 180);
        test_output_hold();
        test_random_mix(1'b1, 1'b0, 180);
        test_random_mix(1'b0, 1'b1, 180);
        test_fill_table();
        test_full_table();
        wait_idle();
        $display("Run covered %0d corners over all four key-part settings, %0d results checked.",
                 accepted_corners, checked_results);
        $display("%0d vertices stored, %0d corners refused on a full table, %0d group ends.",
                 stored_vertices, refused, group_ends);
        if (errors == 0 && pending_results.size() == 0)
            $display("** vertex_dedup_index_assigner_top: PASSED **");
        else
            $display("** vertex_dedup_index_assigner_top: FAILED **");
        $finish;
    end

endmodule
